### src/bam_pkg.sv
`timescale 1ns / 1ps

package bam_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;
   localparam int DEF_MAX_BLOCK  = 64;

   localparam int CH_W       = 8;
   localparam int SUM_W      = 20;
   localparam int PEND_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int FW_W       = 12;
   localparam int FH_W       = 12;
   localparam int BSZ_W      = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE   = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
   localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT = 12'd480;
   localparam logic [BSZ_W-1:0] RST_BLOCK_SIZE   = 7'd6;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SUM,
      ST_SUM_LAST,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_STORE,
      ST_SYNC_GO,
      ST_SYNC_WAIT
   } bam_state_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic exec;
      logic sum_rd;
      logic avg_start;
      logic store;
      logic sync_start;
      logic sync_load;
   } bam_cmd_type;

   typedef struct packed {
      logic dirty;
      logic clear_last;
      logic res_pend;
      logic rsp_busy;
      logic fin;
      logic sum_last;
      logic more_blocks;
      logic avg_busy;
      logic sync_busy;
   } bam_status_type;

endpackage

### src/bam_div.sv
`timescale 1ns / 1ps

module bam_div #(
   parameter int N = 26,
   parameter int D = 13,
   parameter int L = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [L-1:0][N-1:0] dividend,
   input  logic [D-1:0]        divisor,
   output logic                busy,
   output logic [L-1:0][N-1:0] quotient,
   output logic [L-1:0][D-1:0] remainder
);

   localparam int STEP_W = $clog2(N + 1);

   logic [L-1:0][N-1:0] quo_ff, quo_in;
   logic [L-1:0][D-1:0] rem_ff, rem_in;
   logic [D-1:0]        div_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                busy_ff;
   logic [L-1:0][D:0]   shifted;
   logic [L-1:0]        qbit;

   always_comb begin
      for (int l = 0; l < L; l++) begin
         shifted[l] = {rem_ff[l], quo_ff[l][N-1]};
         qbit[l]    = (shifted[l] >= {1'b0, div_ff});
         if (qbit[l]) begin
            rem_in[l] = D'(shifted[l] - {1'b0, div_ff});
         end else begin
            rem_in[l] = D'(shifted[l]);
         end
         quo_in[l] = N'({quo_ff[l], qbit[l]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(N - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### src/bam_ctrl.sv
`timescale 1ns / 1ps

module bam_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bam_pkg::bam_status_type st,
   output bam_pkg::bam_cmd_type    cmd
);

   bam_pkg::bam_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bam_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bam_pkg::ST_CLEAR: begin
            if (st.clear_last) state_in = bam_pkg::ST_IDLE;
         end
         bam_pkg::ST_IDLE: begin
            if (st.dirty) state_in = bam_pkg::ST_SYNC_GO;
            else if (req_valid) state_in = bam_pkg::ST_EXEC;
         end
         bam_pkg::ST_EXEC: begin
            if (!(st.res_pend && st.rsp_busy)) begin
               state_in = st.fin ? bam_pkg::ST_SUM : bam_pkg::ST_IDLE;
            end
         end
         bam_pkg::ST_SUM: begin
            if (st.sum_last) state_in = bam_pkg::ST_SUM_LAST;
         end
         bam_pkg::ST_SUM_LAST: state_in = bam_pkg::ST_AVG_GO;
         bam_pkg::ST_AVG_GO:   state_in = bam_pkg::ST_AVG_WAIT;
         bam_pkg::ST_AVG_WAIT: begin
            if (!st.avg_busy) state_in = bam_pkg::ST_STORE;
         end
         bam_pkg::ST_STORE: begin
            state_in = st.more_blocks ? bam_pkg::ST_SUM : bam_pkg::ST_IDLE;
         end
         bam_pkg::ST_SYNC_GO:  state_in = bam_pkg::ST_SYNC_WAIT;
         bam_pkg::ST_SYNC_WAIT: begin
            if (!st.sync_busy) state_in = bam_pkg::ST_IDLE;
         end
         default: state_in = bam_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         bam_pkg::ST_CLEAR: cmd.clear_en = 1'b1;
         bam_pkg::ST_IDLE: begin
            req_stall  = st.dirty;
            cmd.accept = !st.dirty && req_valid;
         end
         bam_pkg::ST_EXEC:      cmd.exec = !(st.res_pend && st.rsp_busy);
         bam_pkg::ST_SUM:       cmd.sum_rd = 1'b1;
         bam_pkg::ST_SUM_LAST:  ;
         bam_pkg::ST_AVG_GO:    cmd.avg_start = 1'b1;
         bam_pkg::ST_AVG_WAIT:  ;
         bam_pkg::ST_STORE:     cmd.store = 1'b1;
         bam_pkg::ST_SYNC_GO:   cmd.sync_start = 1'b1;
         bam_pkg::ST_SYNC_WAIT: cmd.sync_load = !st.sync_busy;
         default: ;
      endcase
   end

endmodule

### src/bam_datapath.sv
`timescale 1ns / 1ps

module bam_datapath #(
   parameter int MAX_WIDTH  = bam_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bam_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_BLOCK  = bam_pkg::DEF_MAX_BLOCK
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bam_pkg::bam_cmd_type              cmd,
   output bam_pkg::bam_status_type           st,
   input  logic                              req_op,
   input  logic [bam_pkg::CH_W-1:0]          req_in_blue,
   input  logic [bam_pkg::CH_W-1:0]          req_in_green,
   input  logic [bam_pkg::CH_W-1:0]          req_in_red,
   input  logic [bam_pkg::CH_W-1:0]          req_in_alpha,
   input  logic                              csr_we,
   input  logic [bam_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bam_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bam_pkg::CH_W-1:0]          rsp_out_blue,
   output logic [bam_pkg::CH_W-1:0]          rsp_out_green,
   output logic [bam_pkg::CH_W-1:0]          rsp_out_red,
   output logic [bam_pkg::CH_W-1:0]          rsp_out_alpha,
   output logic                              rsp_last_of_frame
);

   localparam int CH_W    = bam_pkg::CH_W;
   localparam int SUM_W   = bam_pkg::SUM_W;
   localparam int PEND_W  = bam_pkg::PEND_W;
   localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HCNT_W  = $clog2(MAX_HEIGHT + 1);
   localparam int BS_W    = $clog2(MAX_BLOCK + 1);
   localparam int REM_W   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int ACC_W   = SUM_W + $clog2(MAX_BLOCK);
   localparam int CNT_W   = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
   localparam int MUL_W   = 2 * BS_W;
   localparam int PROD_W  = BS_W + WCNT_W;
   localparam int POS_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int ST_DEP  = 2 * MAX_WIDTH;
   localparam int ST_A_W  = $clog2(ST_DEP);

   // configuration
   logic [bam_pkg::FW_W-1:0]  fw_ff;
   logic [bam_pkg::FH_W-1:0]  fh_ff;
   logic [bam_pkg::BSZ_W-1:0] bsz_ff;
   logic                      dirty_ff;
   logic [WCNT_W-1:0]         w_eff;
   logic [HCNT_W-1:0]         h_eff;
   logic [BS_W-1:0]           bs_eff;

   // positions
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [REM_W-1:0] in_rrem_ff, in_rrem_in;
   logic             in_rpar_ff, in_rpar_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [COL_W-1:0] out_bidx_ff, out_bidx_in;
   logic [REM_W-1:0] out_crem_ff, out_crem_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [REM_W-1:0] out_rrem_ff, out_rrem_in;
   logic             out_rpar_ff, out_rpar_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [COL_W-1:0] clr_ff;

   // per-item latches
   logic             res_pend_ff, res_zero_ff, last_ff, px_we_ff, first_ff, fin_ff;
   logic [COL_W-1:0] px_col_ff;
   logic [CH_W-1:0]  px_b_ff, px_g_ff, px_r_ff, px_a_ff;

   // block row finish
   logic [WCNT_W-1:0] fin_x_ff;
   logic [REM_W-1:0]  fin_k_ff;
   logic [BS_W-1:0]   kcnt_ff;
   logic [COL_W-1:0]  fin_bidx_ff;
   logic [BS_W-1:0]   fin_rows_ff;
   logic              fin_bank_ff;
   logic              rd_vld_ff;
   logic [3:0][ACC_W-1:0] acc_ff;
   logic [MUL_W-1:0]  cnt_prod;

   // memories
   logic [4*SUM_W-1:0] sum_mem [MAX_WIDTH];
   logic [4*SUM_W-1:0] sum_rd_ff;
   logic [4*CH_W-1:0]  avg_mem [ST_DEP];
   logic [4*CH_W-1:0]  avg_rd_ff;
   logic               sum_we;
   logic [COL_W-1:0]   sum_waddr;
   logic [4*SUM_W-1:0] sum_wdata;
   logic [COL_W-1:0]   sum_raddr;
   logic [ST_A_W-1:0]  avg_raddr, avg_waddr;

   // response
   logic             rsp_valid_ff;
   logic [CH_W-1:0]  rsp_b_ff, rsp_g_ff, rsp_r_ff, rsp_a_ff;
   logic             rsp_last_ff;

   // accept-time logic
   logic             emit, out_oor, in_oor, o_wrap, i_wrap, fin_now, first_now;
   logic [COL_W-1:0] oc, obidx;
   logic [ROW_W-1:0] orow;
   logic [REM_W-1:0] ocrem, orrem;
   logic             orpar, last_now;
   logic [BS_W-1:0]  rows_now;
   logic [PROD_W-1:0] pend_add;

   // dividers
   logic [3:0][ACC_W-1:0] avg_q;
   logic [3:0][CNT_W-1:0] avg_r;
   logic                  avg_busy;
   logic [2:0][POS_W-1:0] sync_dvd, sync_q;
   logic [2:0][BS_W-1:0]  sync_r;
   logic                  sync_busy;

   always_comb begin
      if (fw_ff == '0) w_eff = WCNT_W'(1);
      else if (32'(fw_ff) > MAX_WIDTH) w_eff = WCNT_W'(MAX_WIDTH);
      else w_eff = WCNT_W'(fw_ff);
      if (fh_ff == '0) h_eff = HCNT_W'(1);
      else if (32'(fh_ff) > MAX_HEIGHT) h_eff = HCNT_W'(MAX_HEIGHT);
      else h_eff = HCNT_W'(fh_ff);
      if (bsz_ff == '0) bs_eff = BS_W'(1);
      else if (32'(bsz_ff) > MAX_BLOCK) bs_eff = BS_W'(MAX_BLOCK);
      else bs_eff = BS_W'(bsz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff    <= bam_pkg::RST_FRAME_WIDTH;
         fh_ff    <= bam_pkg::RST_FRAME_HEIGHT;
         bsz_ff   <= bam_pkg::RST_BLOCK_SIZE;
         dirty_ff <= 1'b0;
      end else begin
         if (cmd.sync_start) dirty_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               bam_pkg::CSR_FRAME_WIDTH:  begin
                  fw_ff    <= csr_data;
                  dirty_ff <= 1'b1;
               end
               bam_pkg::CSR_FRAME_HEIGHT: begin
                  fh_ff    <= csr_data;
                  dirty_ff <= 1'b1;
               end
               bam_pkg::CSR_BLOCK_SIZE:   begin
                  bsz_ff   <= csr_data[bam_pkg::BSZ_W-1:0];
                  dirty_ff <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // output side: position, store address, advance
   always_comb begin
      emit    = (pend_ff != '0);
      out_oor = (WCNT_W'(out_col_ff) >= w_eff) || (HCNT_W'(out_row_ff) >= h_eff);
      oc      = out_oor ? '0 : out_col_ff;
      obidx   = out_oor ? '0 : out_bidx_ff;
      ocrem   = out_oor ? '0 : out_crem_ff;
      orow    = out_oor ? '0 : out_row_ff;
      orrem   = out_oor ? '0 : out_rrem_ff;
      orpar   = out_oor ? 1'b0 : out_rpar_ff;
      avg_raddr = ST_A_W'(obidx) + (orpar ? ST_A_W'(MAX_WIDTH) : ST_A_W'(0));
      last_now  = (HCNT_W'(orow) == h_eff - HCNT_W'(1)) && (WCNT_W'(oc) == w_eff - WCNT_W'(1));
      o_wrap    = (WCNT_W'(oc) + WCNT_W'(1)) >= w_eff;

      out_col_in  = oc + COL_W'(1);
      out_bidx_in = obidx;
      out_crem_in = ocrem + REM_W'(1);
      out_row_in  = orow;
      out_rrem_in = orrem;
      out_rpar_in = orpar;
      if (BS_W'(ocrem) + BS_W'(1) == bs_eff) begin
         out_crem_in = '0;
         out_bidx_in = obidx + COL_W'(1);
      end
      if (o_wrap) begin
         out_col_in  = '0;
         out_crem_in = '0;
         out_bidx_in = '0;
         if ((HCNT_W'(orow) + HCNT_W'(1)) >= h_eff) begin
            out_row_in  = '0;
            out_rrem_in = '0;
            out_rpar_in = 1'b0;
         end else begin
            out_row_in = orow + ROW_W'(1);
            if (BS_W'(orrem) + BS_W'(1) == bs_eff) begin
               out_rrem_in = '0;
               out_rpar_in = !orpar;
            end else begin
               out_rrem_in = orrem + REM_W'(1);
            end
         end
      end
   end

   // input side
   always_comb begin
      in_oor    = (WCNT_W'(in_col_ff) >= w_eff) || (HCNT_W'(in_row_ff) >= h_eff);
      first_now = (in_rrem_ff == '0);
      rows_now  = BS_W'(in_rrem_ff) + BS_W'(1);
      fin_now   = !in_oor && (req_op == bam_pkg::OP_PIXEL)
                  && (WCNT_W'(in_col_ff) == w_eff - WCNT_W'(1))
                  && ((rows_now == bs_eff) || (HCNT_W'(in_row_ff) == h_eff - HCNT_W'(1)));
      pend_add  = PROD_W'(rows_now) * PROD_W'(w_eff);
      i_wrap    = (WCNT_W'(in_col_ff) + WCNT_W'(1)) >= w_eff;

      in_col_in  = in_col_ff + COL_W'(1);
      in_row_in  = in_row_ff;
      in_rrem_in = in_rrem_ff;
      in_rpar_in = in_rpar_ff;
      if (in_oor) begin
         in_col_in  = '0;
         in_row_in  = '0;
         in_rrem_in = '0;
         in_rpar_in = 1'b0;
      end else if (i_wrap) begin
         in_col_in = '0;
         if ((HCNT_W'(in_row_ff) + HCNT_W'(1)) >= h_eff) begin
            in_row_in  = '0;
            in_rrem_in = '0;
            in_rpar_in = 1'b0;
         end else begin
            in_row_in = in_row_ff + ROW_W'(1);
            if (rows_now == bs_eff) begin
               in_rrem_in = '0;
               in_rpar_in = !in_rpar_ff;
            end else begin
               in_rrem_in = in_rrem_ff + REM_W'(1);
            end
         end
      end

      pend_in = pend_ff - (emit ? PEND_W'(1) : PEND_W'(0))
                + (fin_now ? PEND_W'(pend_add) : PEND_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_rrem_ff  <= '0;
         in_rpar_ff  <= 1'b0;
         out_col_ff  <= '0;
         out_bidx_ff <= '0;
         out_crem_ff <= '0;
         out_row_ff  <= '0;
         out_rrem_ff <= '0;
         out_rpar_ff <= 1'b0;
         pend_ff     <= '0;
         clr_ff      <= '0;
         res_pend_ff <= 1'b0;
         px_we_ff    <= 1'b0;
         fin_ff      <= 1'b0;
         rd_vld_ff   <= 1'b0;
         fin_x_ff    <= '0;
         fin_k_ff    <= '0;
         fin_bidx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_en) clr_ff <= clr_ff + COL_W'(1);
         if (cmd.accept) begin
            pend_ff     <= pend_in;
            res_pend_ff <= emit || (req_op == bam_pkg::OP_DRAIN);
            px_we_ff    <= (req_op == bam_pkg::OP_PIXEL) && !in_oor;
            fin_ff      <= fin_now;
            fin_x_ff    <= '0;
            fin_k_ff    <= '0;
            fin_bidx_ff <= '0;
            if (emit) begin
               out_col_ff  <= out_col_in;
               out_bidx_ff <= out_bidx_in;
               out_crem_ff <= out_crem_in;
               out_row_ff  <= out_row_in;
               out_rrem_ff <= out_rrem_in;
               out_rpar_ff <= out_rpar_in;
            end
            if (req_op == bam_pkg::OP_PIXEL) begin
               in_col_ff  <= in_col_in;
               in_row_ff  <= in_row_in;
               in_rrem_ff <= in_rrem_in;
               in_rpar_ff <= in_rpar_in;
            end
         end
         if (cmd.sync_load) begin
            out_bidx_ff <= COL_W'(sync_q[0]);
            out_crem_ff <= REM_W'(sync_r[0]);
            out_rpar_ff <= sync_q[1][0];
            out_rrem_ff <= REM_W'(sync_r[1]);
            in_rpar_ff  <= sync_q[2][0];
            in_rrem_ff  <= REM_W'(sync_r[2]);
         end
         rd_vld_ff <= cmd.sum_rd;
         if (cmd.sum_rd) begin
            fin_x_ff <= fin_x_ff + WCNT_W'(1);
            fin_k_ff <= st.sum_last ? '0 : fin_k_ff + REM_W'(1);
         end
         if (cmd.store) fin_bidx_ff <= fin_bidx_ff + COL_W'(1);
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (cmd.exec && res_pend_ff) rsp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_zero_ff <= !emit;
         last_ff     <= last_now;
         first_ff    <= first_now;
         px_col_ff   <= in_col_ff;
         px_b_ff     <= req_in_blue;
         px_g_ff     <= req_in_green;
         px_r_ff     <= req_in_red;
         px_a_ff     <= req_in_alpha;
         fin_rows_ff <= rows_now;
         fin_bank_ff <= in_rpar_ff;
      end
      if (cmd.sum_rd && st.sum_last) kcnt_ff <= BS_W'(fin_k_ff) + BS_W'(1);
      if (cmd.exec || cmd.store) begin
         acc_ff <= '0;
      end else if (rd_vld_ff) begin
         for (int c = 0; c < 4; c++) begin
            acc_ff[c] <= acc_ff[c] + ACC_W'(sum_rd_ff[c*SUM_W +: SUM_W]);
         end
      end
      if (cmd.exec && res_pend_ff) begin
         rsp_b_ff    <= res_zero_ff ? '0 : avg_rd_ff[0*CH_W +: CH_W];
         rsp_g_ff    <= res_zero_ff ? '0 : avg_rd_ff[1*CH_W +: CH_W];
         rsp_r_ff    <= res_zero_ff ? '0 : avg_rd_ff[2*CH_W +: CH_W];
         rsp_a_ff    <= res_zero_ff ? '0 : avg_rd_ff[3*CH_W +: CH_W];
         rsp_last_ff <= res_zero_ff ? 1'b0 : last_ff;
      end
   end

   // column sum memory
   always_comb begin
      sum_we    = cmd.clear_en || (cmd.exec && px_we_ff);
      sum_waddr = cmd.clear_en ? clr_ff : px_col_ff;
      sum_wdata = '0;
      if (!cmd.clear_en) begin
         sum_wdata[0*SUM_W +: SUM_W] = SUM_W'((first_ff ? SUM_W'(0) : sum_rd_ff[0*SUM_W +: SUM_W])
                                              + SUM_W'(px_b_ff));
         sum_wdata[1*SUM_W +: SUM_W] = SUM_W'((first_ff ? SUM_W'(0) : sum_rd_ff[1*SUM_W +: SUM_W])
                                              + SUM_W'(px_g_ff));
         sum_wdata[2*SUM_W +: SUM_W] = SUM_W'((first_ff ? SUM_W'(0) : sum_rd_ff[2*SUM_W +: SUM_W])
                                              + SUM_W'(px_r_ff));
         sum_wdata[3*SUM_W +: SUM_W] = SUM_W'((first_ff ? SUM_W'(0) : sum_rd_ff[3*SUM_W +: SUM_W])
                                              + SUM_W'(px_a_ff));
      end
      sum_raddr = cmd.sum_rd ? fin_x_ff[COL_W-1:0] : in_col_ff;
      avg_waddr = ST_A_W'(fin_bidx_ff) + (fin_bank_ff ? ST_A_W'(MAX_WIDTH) : ST_A_W'(0));
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
      if (cmd.accept || cmd.sum_rd) sum_rd_ff <= sum_mem[sum_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         avg_mem[avg_waddr] <= {avg_q[3][CH_W-1:0], avg_q[2][CH_W-1:0],
                                avg_q[1][CH_W-1:0], avg_q[0][CH_W-1:0]};
      end
      if (cmd.accept) avg_rd_ff <= avg_mem[avg_raddr];
   end

   assign cnt_prod = MUL_W'(kcnt_ff) * MUL_W'(fin_rows_ff);

   bam_div #(.N(ACC_W), .D(CNT_W), .L(4)) u_avg_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.avg_start),
      .dividend  (acc_ff),
      .divisor   (CNT_W'(cnt_prod)),
      .busy      (avg_busy),
      .quotient  (avg_q),
      .remainder (avg_r)
   );

   assign sync_dvd[0] = POS_W'(out_col_ff);
   assign sync_dvd[1] = POS_W'(out_row_ff);
   assign sync_dvd[2] = POS_W'(in_row_ff);

   bam_div #(.N(POS_W), .D(BS_W), .L(3)) u_sync_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.sync_start),
      .dividend  (sync_dvd),
      .divisor   (bs_eff),
      .busy      (sync_busy),
      .quotient  (sync_q),
      .remainder (sync_r)
   );

   always_comb begin
      st             = '0;
      st.dirty       = dirty_ff;
      st.clear_last  = (clr_ff == COL_W'(MAX_WIDTH - 1));
      st.res_pend    = res_pend_ff;
      st.rsp_busy    = rsp_valid_ff && rsp_stall;
      st.fin         = fin_ff;
      st.sum_last    = (BS_W'(fin_k_ff) == bs_eff - BS_W'(1))
                       || (fin_x_ff == w_eff - WCNT_W'(1));
      st.more_blocks = (fin_x_ff < w_eff) && (avg_r[0] == avg_r[0]);
      st.avg_busy    = avg_busy;
      st.sync_busy   = sync_busy;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_blue      = rsp_b_ff;
   assign rsp_out_green     = rsp_g_ff;
   assign rsp_out_red       = rsp_r_ff;
   assign rsp_out_alpha     = rsp_a_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

### src/block_average_mosaic_core.sv
`timescale 1ns / 1ps
// Block-average mosaic over a raster stream of four-channel 8-bit pixels.
// Input channel req_*: req_op selects a pixel (OP_PIXEL) or a drain (OP_DRAIN);
// a transfer happens when req_valid is high and req_stall low. Result
// channel rsp_*: at most one block-averaged pixel per transfer, raster
// order, one block row behind the input; rsp_last_of_frame marks the
// frame's last pixel. Drains pull out the final block row; a drain with
// nothing pending returns all zeros. csr_* writes frame_width, frame_height
// and block_size. Timing: the result register loads in the EXEC state
// after the transfer, once any earlier result has drained, and the input
// takes no new item until the last has executed. The item that closes a
// block row also runs the block-row pass: each column is read through the
// column-sum memory and each block's sums are divided by a serial divider;
// req_stall is high meanwhile. After a register write req_stall stays high
// while the block-position counters are recomputed by a serial divider.
// Reset: synchronous; all counters clear and the column-sum memory is
// zeroed with req_stall high. The block-average store is not cleared. A
// stalled result holds in the output register; the block takes the next
// item but waits before loading a new result until it drains.

module block_average_mosaic_core #(
   parameter int MAX_WIDTH  = bam_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bam_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_BLOCK  = bam_pkg::DEF_MAX_BLOCK
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [bam_pkg::CH_W-1:0]       req_in_blue,
   input  logic [bam_pkg::CH_W-1:0]       req_in_green,
   input  logic [bam_pkg::CH_W-1:0]       req_in_red,
   input  logic [bam_pkg::CH_W-1:0]       req_in_alpha,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bam_pkg::CH_W-1:0]       rsp_out_blue,
   output logic [bam_pkg::CH_W-1:0]       rsp_out_green,
   output logic [bam_pkg::CH_W-1:0]       rsp_out_red,
   output logic [bam_pkg::CH_W-1:0]       rsp_out_alpha,
   output logic                           rsp_last_of_frame,
   input  logic                           csr_we,
   input  logic [bam_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bam_pkg::CSR_DATA_W-1:0] csr_data
);

   bam_pkg::bam_cmd_type    cmd;
   bam_pkg::bam_status_type st;

   bam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   bam_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_BLOCK  (MAX_BLOCK)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_op            (req_op),
      .req_in_blue       (req_in_blue),
      .req_in_green      (req_in_green),
      .req_in_red        (req_in_red),
      .req_in_alpha      (req_in_alpha),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_blue      (rsp_out_blue),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_alpha     (rsp_out_alpha),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("two transfers in consecutive cycles");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.exec))
      else $error("result appeared without an item being executed");

   a_clear_stalls: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input open right after reset");

   a_no_store_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> !st.avg_busy)
      else $error("average stored while divider still running");

endmodule
